FILE: rtl/core/dha_pkg.sv
`default_nettype none
package dha_pkg;

  // coordinate and output formats
  localparam int CW        = 18;
  localparam int AFB       = 13;
  localparam int AW        = 16;
  localparam int ACC_FRAC  = 50;
  localparam int CSTEPS    = 52;
  localparam int NORM_BITS = 60;

  // derived widths
  localparam int PW   = 2 * CW;          // coordinate product
  localparam int TW   = PW + 1;          // cross product component
  localparam int DMW  = 2 * TW;          // |t1.t2|
  localparam int DW   = DMW + 2;         // signed t1.t2
  localparam int MMW  = TW + CW;         // |(a x b).c|
  localparam int MW   = MMW + 2;         // signed mixed product
  localparam int B2W  = 2 * CW;          // |b|^2
  localparam int SW   = CW + 32;         // sqrt(|b|^2 * 2^64)
  localparam int RW   = SW + 3;          // square root remainder
  localparam int YW   = SW + MMW;        // |b| * |m|
  localparam int NW   = DMW + 32;        // common frame for x and y
  localparam int NSH  = $clog2(NW);      // normalizer stages
  localparam int CXW  = NORM_BITS + 3;   // rotator x and y
  localparam int ZW   = ACC_FRAC + 3;    // angle accumulator
  localparam int SH   = ACC_FRAC - AFB;  // accumulator to output shift
  localparam int RRW  = ZW + 1 - SH;     // rounded magnitude
  localparam int SIW  = $clog2(CSTEPS);  // rotator step index

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic degen;
    logic dneg;
    logic mneg;
    logic zero;
  } flags_t;

  typedef struct packed {
    flags_t          fl;
    logic [DMW-1:0]  dotm;
    logic [MMW-1:0]  mmag;
  } side_t;

  typedef struct packed {
    logic [B2W-1:0] rad;
    logic [RW-1:0]  rem;
    logic [SW-1:0]  root;
    side_t          side;
  } sq_t;

  typedef struct packed {
    logic signed [CXW-1:0] x;
    logic signed [CXW-1:0] y;
    logic signed [ZW-1:0]  z;
    flags_t                fl;
  } cord_t;

  typedef logic [ZW-1:0] atan_tab_t [CSTEPS];

  // long division by shift and subtract, for building the constant tables
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], n[k]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) * 2^62 by series, i >= 1
  function automatic logic [63:0] atan_pow2(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    int e;
    sum = '0;
    for (int k = 0; k < 63; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
        if (k[0]) sum = sum - term;
        else sum = sum + term;
      end
    end
    return sum;
  endfunction

  // atan(1/3) * 2^62 by series
  function automatic logic [63:0] atan_third();
    logic [63:0] one;
    logic [63:0] pw;
    logic [63:0] sum;
    logic [63:0] term;
    logic done;
    one  = 64'd1 << 62;
    pw   = 64'd3;
    sum  = '0;
    done = 1'b0;
    for (int k = 0; k < 40; k++) begin
      if (!done) begin
        term = udiv64(udiv64(one, pw), 64'(2 * k + 1));
        if (k[0]) sum = sum - term;
        else sum = sum + term;
        if (term == 64'd0 || pw > udiv64(one, 64'd9)) done = 1'b1;
        else pw = pw * 64'd9;
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] quarter_pi();
    return atan_pow2(1) + atan_third();
  endfunction

  function automatic atan_tab_t atan_table();
    atan_tab_t t;
    logic [63:0] v;
    for (int i = 0; i < CSTEPS; i++) begin
      v = (i == 0) ? quarter_pi() : atan_pow2(i);
      t[i] = ZW'((v + (64'd1 << (61 - ACC_FRAC))) >> (62 - ACC_FRAC));
    end
    return t;
  endfunction

  localparam logic [63:0] PI62   = quarter_pi() << 2;
  localparam logic [63:0] PI_ACC = (PI62 + (64'd1 << (61 - ACC_FRAC))) >> (62 - ACC_FRAC);
  localparam logic [63:0] PI_OUT = (PI62 + (64'd1 << (61 - AFB))) >> (62 - AFB);
  localparam atan_tab_t   ATAN_TAB = atan_table();

endpackage
`default_nettype wire

FILE: rtl/core/dha_front.sv
`default_nettype none
module dha_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  dha_pkg::coord_t a [3],
  input  dha_pkg::coord_t b [3],
  input  dha_pkg::coord_t c [3],
  output logic           out_valid,
  output dha_pkg::sq_t   out_data
);
  import dha_pkg::*;

  logic                  s1_v, s2_v, s3_v, s4_v, s5_v;
  logic signed [PW-1:0]  s1_p1 [6];
  logic signed [PW-1:0]  s1_p2 [6];
  logic signed [PW-1:0]  s1_bb [3];
  coord_t                s1_c [3];
  logic signed [TW-1:0]  s2_t1 [3];
  logic signed [TW-1:0]  s2_t2 [3];
  logic [B2W-1:0]        s2_b2;
  coord_t                s2_c [3];
  logic signed [DMW-1:0] s3_q [3];
  logic signed [MMW-1:0] s3_r [3];
  logic [B2W-1:0]        s3_b2;
  logic                  s3_degen;
  logic signed [DW-1:0]  s4_dot;
  logic signed [MW-1:0]  s4_m;
  logic [B2W-1:0]        s4_b2;
  logic                  s4_degen;
  logic signed [DW-1:0]  dot_abs;
  logic signed [MW-1:0]  m_abs;
  sq_t                   s5_d;

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
    end else if (adv) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
    end
  end

  // form coordinate products for both cross products and |b|^2
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_p1[0] <= a[1] * b[2];
      s1_p1[1] <= a[2] * b[1];
      s1_p1[2] <= a[2] * b[0];
      s1_p1[3] <= a[0] * b[2];
      s1_p1[4] <= a[0] * b[1];
      s1_p1[5] <= a[1] * b[0];
      s1_p2[0] <= b[1] * c[2];
      s1_p2[1] <= b[2] * c[1];
      s1_p2[2] <= b[2] * c[0];
      s1_p2[3] <= b[0] * c[2];
      s1_p2[4] <= b[0] * c[1];
      s1_p2[5] <= b[1] * c[0];
      for (int k = 0; k < 3; k++) begin
        s1_bb[k] <= b[k] * b[k];
        s1_c[k]  <= c[k];
      end
    end
  end

  // take differences into t1, t2; sum |b|^2
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s2_t1[k] <= TW'(s1_p1[2*k]) - TW'(s1_p1[2*k+1]);
        s2_t2[k] <= TW'(s1_p2[2*k]) - TW'(s1_p2[2*k+1]);
        s2_c[k]  <= s1_c[k];
      end
      s2_b2 <= $unsigned(s1_bb[0]) + $unsigned(s1_bb[1]) + $unsigned(s1_bb[2]);
    end
  end

  // multiply terms of t1.t2 and t1.c; flag zero cross products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s3_q[k] <= s2_t1[k] * s2_t2[k];
        s3_r[k] <= s2_t1[k] * s2_c[k];
      end
      s3_b2    <= s2_b2;
      s3_degen <= (s2_t1[0] == '0 && s2_t1[1] == '0 && s2_t1[2] == '0) ||
                  (s2_t2[0] == '0 && s2_t2[1] == '0 && s2_t2[2] == '0);
    end
  end

  // sum the dot products
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_dot   <= DW'(s3_q[0]) + DW'(s3_q[1]) + DW'(s3_q[2]);
      s4_m     <= MW'(s3_r[0]) + MW'(s3_r[1]) + MW'(s3_r[2]);
      s4_b2    <= s3_b2;
      s4_degen <= s3_degen;
    end
  end

  // split into sign and magnitude, seed the square root
  assign dot_abs = s4_dot[DW-1] ? -s4_dot : s4_dot;
  assign m_abs   = s4_m[MW-1] ? -s4_m : s4_m;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_d.rad           <= s4_b2;
      s5_d.rem           <= '0;
      s5_d.root          <= '0;
      s5_d.side.fl.degen <= s4_degen;
      s5_d.side.fl.dneg  <= s4_dot[DW-1];
      s5_d.side.fl.mneg  <= s4_m[MW-1];
      s5_d.side.fl.zero  <= 1'b0;
      s5_d.side.dotm     <= dot_abs[DMW-1:0];
      s5_d.side.mmag     <= m_abs[MMW-1:0];
    end
  end

  assign out_valid = s5_v;
  assign out_data  = s5_d;

endmodule
`default_nettype wire

FILE: rtl/core/dha_sqrt_cell.sv
`default_nettype none
module dha_sqrt_cell (
  input  logic         clk,
  input  logic         rst,
  input  logic         adv,
  input  logic         in_valid,
  input  dha_pkg::sq_t in_data,
  output logic         out_valid,
  output dha_pkg::sq_t out_data
);
  import dha_pkg::*;

  logic [RW-1:0] acc;
  logic [RW-1:0] trial;
  logic          ge;
  sq_t           nxt;

  // one root bit: bring down two radicand bits, try the next digit
  assign acc   = {in_data.rem[RW-3:0], in_data.rad[B2W-1 -: 2]};
  assign trial = RW'({in_data.root, 2'b01});
  assign ge    = (acc >= trial);

  always_comb begin
    nxt      = in_data;
    nxt.rad  = {in_data.rad[B2W-3:0], 2'b00};
    nxt.rem  = ge ? (acc - trial) : acc;
    nxt.root = {in_data.root[SW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dha_norm.sv
`default_nettype none
module dha_norm (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  dha_pkg::sq_t   in_data,
  output logic           out_valid,
  output dha_pkg::cord_t out_data
);
  import dha_pkg::*;

  localparam int SLW = SW / 2;
  localparam int SHW = SW - SLW;
  localparam int MLW = (MMW + 1) / 2;
  localparam int MHW = MMW - MLW;
  localparam int LRW = SW + MLW;
  localparam int HRW = SW + MHW;

  logic                 n1_v, n2_v;
  logic [SLW+MLW-1:0]   n1_ll;
  logic [SHW+MLW-1:0]   n1_hl;
  logic [SLW+MHW-1:0]   n1_lh;
  logic [SHW+MHW-1:0]   n1_hh;
  logic [DMW-1:0]       n1_dotm, n2_dotm;
  flags_t               n1_fl, n2_fl;
  logic [LRW-1:0]       n2_rl;
  logic [HRW-1:0]       n2_rh;
  logic                 nv  [NSH+1];
  logic [NW-1:0]        nx  [NSH+1];
  logic [NW-1:0]        ny  [NSH+1];
  flags_t               nfl [NSH+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_v  <= 1'b0;
      n2_v  <= 1'b0;
      nv[0] <= 1'b0;
    end else if (adv) begin
      n1_v  <= in_valid;
      n2_v  <= n1_v;
      nv[0] <= n2_v;
    end
  end

  // split |b| * |m| into four partial products
  always_ff @(posedge clk) begin
    if (adv) begin
      n1_ll   <= in_data.root[SLW-1:0] * in_data.side.mmag[MLW-1:0];
      n1_hl   <= in_data.root[SW-1:SLW] * in_data.side.mmag[MLW-1:0];
      n1_lh   <= in_data.root[SLW-1:0] * in_data.side.mmag[MMW-1:MLW];
      n1_hh   <= in_data.root[SW-1:SLW] * in_data.side.mmag[MMW-1:MLW];
      n1_dotm <= in_data.side.dotm;
      n1_fl   <= in_data.side.fl;
    end
  end

  // combine into two rows
  always_ff @(posedge clk) begin
    if (adv) begin
      n2_rl   <= LRW'(n1_ll) + (LRW'(n1_hl) << SLW);
      n2_rh   <= HRW'(n1_lh) + (HRW'(n1_hh) << SLW);
      n2_dotm <= n1_dotm;
      n2_fl   <= n1_fl;
    end
  end

  // place x and y in one frame (x scaled by 2^32 to match y)
  always_ff @(posedge clk) begin
    if (adv) begin
      nx[0]  <= {n2_dotm, 32'b0};
      ny[0]  <= NW'(YW'(n2_rl) + (YW'(n2_rh) << MLW));
      nfl[0] <= n2_fl;
    end
  end

  // shift both left until the larger one fills the top bit
  for (genvar g = 0; g < NSH; g++) begin : g_shift
    localparam int AMT = 1 << (NSH - 1 - g);
    logic [NW-1:0] both;
    logic          hit;
    flags_t        fl_next;

    assign both = nx[g] | ny[g];
    assign hit  = ~|both[NW-1 -: AMT];

    always_comb begin
      fl_next = nfl[g];
      if (g == 0) begin
        fl_next.zero = ~|both;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        nv[g+1] <= 1'b0;
      end else if (adv) begin
        nv[g+1] <= nv[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        nx[g+1]  <= hit ? (nx[g] << AMT) : nx[g];
        ny[g+1]  <= hit ? (ny[g] << AMT) : ny[g];
        nfl[g+1] <= fl_next;
      end
    end
  end

  // keep the top bits as rotator start values
  assign out_valid   = nv[NSH];
  assign out_data.x  = CXW'(nx[NSH][NW-1 -: NORM_BITS]);
  assign out_data.y  = CXW'(ny[NSH][NW-1 -: NORM_BITS]);
  assign out_data.z  = '0;
  assign out_data.fl = nfl[NSH];

endmodule
`default_nettype wire

FILE: rtl/core/dha_cordic_cell.sv
`default_nettype none
module dha_cordic_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic [dha_pkg::SIW-1:0] step,
  input  logic                    in_valid,
  input  dha_pkg::cord_t          in_data,
  output logic                    out_valid,
  output dha_pkg::cord_t          out_data
);
  import dha_pkg::*;

  logic signed [CXW-1:0] x, y, dx, dy;
  logic signed [ZW-1:0]  z, da;
  cord_t                 nxt;

  assign x  = in_data.x;
  assign y  = in_data.y;
  assign z  = in_data.z;
  assign dx = y >>> step;
  assign dy = x >>> step;
  assign da = $signed(ATAN_TAB[step]);

  // rotate toward the x axis, accumulate the angle
  always_comb begin
    nxt = in_data;
    if (!y[CXW-1]) begin
      nxt.x = x + dx;
      nxt.y = y - dy;
      nxt.z = z + da;
    end else begin
      nxt.x = x - dx;
      nxt.y = y + dy;
      nxt.z = z - da;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dihedral_angle.sv
`default_nettype none
// channel  | valid     | ready     | payload
// ---------+-----------+-----------+---------------------------------
// input    | in_valid  | in_ready  | a_x a_y a_z b_x b_y b_z c_x c_y c_z
// output   | out_valid | out_ready | angle degenerate
//
// One request per cycle while the output is not stalled; stages: 5 front (cross and dot products),
// 50 square root cells (one root bit each), 10 normalize, 52 rotator cells,
// 2 round and output. Reset clears only the valid bits of the chain.
// A stalled output holds the whole chain; in_ready drops only while a result
// waits and out_ready is low.
module dihedral_angle (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [17:0]        a_x,
  input  logic signed [17:0]        a_y,
  input  logic signed [17:0]        a_z,
  input  logic signed [17:0]        b_x,
  input  logic signed [17:0]        b_y,
  input  logic signed [17:0]        b_z,
  input  logic signed [17:0]        c_x,
  input  logic signed [17:0]        c_y,
  input  logic signed [17:0]        c_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [15:0]        angle,
  output logic                      degenerate
);
  import dha_pkg::*;

  logic                  adv;
  coord_t                va [3];
  coord_t                vb [3];
  coord_t                vc [3];
  logic                  sq_v [SW+1];
  sq_t                   sq_d [SW+1];
  logic                  cd_v [CSTEPS+1];
  cord_t                 cd_d [CSTEPS+1];
  cord_t                 cf;
  logic signed [ZW:0]    theta;
  logic [ZW:0]           mag;
  logic [ZW:0]           rsum;
  logic                  p1_v;
  logic [RRW-1:0]        p1_r;
  flags_t                p1_fl;
  logic [RRW-1:0]        rclamp;
  logic [AW-1:0]         angle_r;
  logic                  degen_r;
  logic                  out_v;

  // the whole chain moves unless a result is stuck at the output
  assign adv      = ~out_v | out_ready;
  assign in_ready = adv;

  assign va[0] = a_x;
  assign va[1] = a_y;
  assign va[2] = a_z;
  assign vb[0] = b_x;
  assign vb[1] = b_y;
  assign vb[2] = b_z;
  assign vc[0] = c_x;
  assign vc[1] = c_y;
  assign vc[2] = c_z;

  dha_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .a         (va),
    .b         (vb),
    .c         (vc),
    .out_valid (sq_v[0]),
    .out_data  (sq_d[0])
  );

  // square root of |b|^2 * 2^64, one bit per cell
  for (genvar g = 0; g < SW; g++) begin : g_sqrt
    dha_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (sq_v[g]),
      .in_data   (sq_d[g]),
      .out_valid (sq_v[g+1]),
      .out_data  (sq_d[g+1])
    );
  end

  dha_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sq_v[SW]),
    .in_data   (sq_d[SW]),
    .out_valid (cd_v[0]),
    .out_data  (cd_d[0])
  );

  // vectoring rotator, one step per cell
  for (genvar g = 0; g < CSTEPS; g++) begin : g_cordic
    dha_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .step      (SIW'(g)),
      .in_valid  (cd_v[g]),
      .in_data   (cd_d[g]),
      .out_valid (cd_v[g+1]),
      .out_data  (cd_d[g+1])
    );
  end

  // fold into the obtuse half, drop negatives, round to output scale
  assign cf    = cd_d[CSTEPS];
  assign theta = cf.fl.dneg ? ($signed((ZW+1)'(PI_ACC)) - (ZW+1)'(cf.z)) : (ZW+1)'(cf.z);
  assign mag   = theta[ZW] ? '0 : $unsigned(theta);
  assign rsum  = mag + ((ZW+1)'(1) << (SH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v  <= 1'b0;
      out_v <= 1'b0;
    end else if (adv) begin
      p1_v  <= cd_v[CSTEPS];
      out_v <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r  <= rsum[ZW:SH];
      p1_fl <= cf.fl;
    end
  end

  // clamp to pi, apply the sign of the mixed product
  assign rclamp = (p1_r > RRW'(PI_OUT)) ? RRW'(PI_OUT) : p1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      degen_r <= p1_fl.degen;
      if (p1_fl.degen || p1_fl.zero) begin
        angle_r <= '0;
      end else if (p1_fl.mneg) begin
        angle_r <= AW'(-rclamp);
      end else begin
        angle_r <= AW'(rclamp);
      end
    end
  end

  assign out_valid  = out_v;
  assign angle      = angle_r;
  assign degenerate = degen_r;

endmodule
`default_nettype wire

FILE: bench/tb_dihedral_angle.sv
`timescale 1ns / 1ps
`default_nettype none

module tb_dihedral_angle;
  import dha_pkg::*;

  localparam int WATCH_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 140;
  localparam int RANDOM_ITEMS = 1530;

  typedef struct {
    logic signed [15:0] angle;
    logic               degen;
  } torsion_t;

  typedef coord_t triple_t [9];

  // Torsion predictor and queue of pending angles
  class torsion_board;
    torsion_t       pending_q[$];
    int             errors;
    longint unsigned arctan[CSTEPS];
    longint unsigned pi_q62;

    function new();
      longint unsigned qtr;
      qtr = arctan_pow2(1) + arctan_third();
      pi_q62 = qtr * 4;
      for (int i = 0; i < CSTEPS; i++) begin
        arctan[i] = ((i == 0 ? qtr : arctan_pow2(i)) + (64'd1 << (61 - ACC_FRAC)))
                    >> (62 - ACC_FRAC);
      end
      errors = 0;
    endfunction

    // atan(2^-i) at 2^-62 by power series
    function longint unsigned arctan_pow2(int i);
      longint unsigned acc, term;
      int e;
      acc = 0;
      for (int k = 0; k < 64; k++) begin
        e = i * (2 * k + 1);
        if (e > 62) break;
        term = (64'd1 << (62 - e)) / longint'(2 * k + 1);
        if (k % 2) acc -= term;
        else acc += term;
      end
      return acc;
    endfunction

    // atan(1/3) at 2^-62
    function longint unsigned arctan_third();
      longint unsigned one, pw, acc, term;
      one = 64'd1 << 62;
      pw = 3;
      acc = 0;
      for (int k = 0; k < 64; k++) begin
        term = one / pw / longint'(2 * k + 1);
        if (k % 2) acc -= term;
        else acc += term;
        if (term == 0 || pw > one / 9) break;
        pw *= 9;
      end
      return acc;
    endfunction

    function int bit_len(logic [127:0] v);
      for (int i = 127; i >= 0; i--) if (v[i]) return i + 1;
      return 0;
    endfunction

    // low 64 bits of v * 2^s, floor for negative s
    function logic [63:0] scale64(logic [127:0] v, int s);
      logic [127:0] t;
      if (s >= 0) return (s < 64) ? (v[63:0] << s) : 64'd0;
      if (-s >= 128) return 64'd0;
      t = v >> (-s);
      return t[63:0];
    endfunction

    function torsion_t torsion(triple_t v);
      torsion_t res;
      longint a[3], b[3], c[3], t1[3], t2[3];
      logic signed [127:0] p[3], q[3], cw[3], dot, mix;
      logic [127:0] dotm, mixm, rad, cc, yp;
      logic [63:0] root, cand, mtop, xv, yv;
      longint unsigned b2, mag, r, pi_out;
      longint x, y, z, dx, dy, theta;
      logic dneg, mneg;
      int es, ey, top, leny;
      for (int i = 0; i < 3; i++) begin
        a[i] = v[i];
        b[i] = v[3 + i];
        c[i] = v[6 + i];
      end
      t1[0] = a[1] * b[2] - a[2] * b[1];
      t1[1] = a[2] * b[0] - a[0] * b[2];
      t1[2] = a[0] * b[1] - a[1] * b[0];
      t2[0] = b[1] * c[2] - b[2] * c[1];
      t2[1] = b[2] * c[0] - b[0] * c[2];
      t2[2] = b[0] * c[1] - b[1] * c[0];
      res.degen = 1'b0;
      res.angle = '0;
      if ((t1[0] == 0 && t1[1] == 0 && t1[2] == 0) ||
          (t2[0] == 0 && t2[1] == 0 && t2[2] == 0)) begin
        res.degen = 1'b1;
        return res;
      end
      for (int i = 0; i < 3; i++) begin
        p[i] = t1[i];
        q[i] = t2[i];
        cw[i] = c[i];
      end
      dot = p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
      mix = p[0] * cw[0] + p[1] * cw[1] + p[2] * cw[2];
      dneg = dot < 0;
      mneg = mix < 0;
      dotm = dneg ? -dot : dot;
      mixm = mneg ? -mix : mix;
      b2 = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
      // floor(sqrt(|b|^2 * 2^64)) bit by bit
      rad = {b2, 64'd0};
      root = '0;
      for (int i = 63; i >= 0; i--) begin
        cand = root | (64'd1 << i);
        cc = {64'd0, cand};
        if (cc * cc <= rad) root = cand;
      end
      es = bit_len(mixm) > 64 ? bit_len(mixm) - 64 : 0;
      mtop = scale64(mixm, -es);
      yp = {64'd0, root} * {64'd0, mtop};
      ey = es - 32;
      top = bit_len(dotm);
      if (yp != 0) begin
        leny = bit_len(yp) + ey;
        if (leny > top) top = leny;
      end
      xv = scale64(dotm, NORM_BITS - top);
      yv = (yp != 0) ? scale64(yp, ey + NORM_BITS - top) : 64'd0;
      if (xv == 0 && yv == 0) return res;
      // vectoring rotation
      x = xv;
      y = yv;
      z = 0;
      for (int i = 0; i < CSTEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += longint'(arctan[i]);
        end else begin
          x -= dx; y += dy; z -= longint'(arctan[i]);
        end
      end
      theta = z;
      if (dneg)
        theta = longint'((pi_q62 + (64'd1 << (61 - ACC_FRAC))) >> (62 - ACC_FRAC)) - z;
      mag = theta < 0 ? 0 : theta;
      r = (mag + (64'd1 << (ACC_FRAC - AFB - 1))) >> (ACC_FRAC - AFB);
      pi_out = (pi_q62 + (64'd1 << (61 - AFB))) >> (62 - AFB);
      if (r > pi_out) r = pi_out;
      res.angle = mneg ? 16'(-r) : 16'(r);
      return res;
    endfunction

    function void note_request(triple_t v);
      pending_q.push_back(torsion(v));
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic signed [15:0] ang, logic deg);
      torsion_t exp_r;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result angle=%0d degenerate=%0b", ang, deg));
        return;
      end
      exp_r = pending_q.pop_front();
      if (ang !== exp_r.angle)
        report($sformatf("angle %0d, want %0d", ang, exp_r.angle));
      if (deg !== exp_r.degen)
        report($sformatf("degenerate %0b, want %0b", deg, exp_r.degen));
    endtask
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  coord_t a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
  logic signed [15:0] angle;
  logic degenerate;

  torsion_board board;
  logic took_request;
  logic calm;
  int idle_cycles = 0;

  dihedral_angle dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .a_x(a_x), .a_y(a_y), .a_z(a_z),
    .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .c_x(c_x), .c_y(c_y), .c_z(c_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .angle(angle), .degenerate(degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample both channels, feed the board, and watch for a hang
  always @(posedge clk) begin
    took_request = 1'b0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        board.note_request('{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z});
        took_request = 1'b1;
      end
      if (out_valid && out_ready) board.check_result(angle, degenerate);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(99) >= 24);
  end

  // Hold valid across requests; drop it only while idling
  task send_request(triple_t v);
    if (!calm) begin
      while ($urandom_range(99) < 24) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    {a_x, a_y, a_z} <= {v[0], v[1], v[2]};
    {b_x, b_y, b_z} <= {v[3], v[4], v[5]};
    {c_x, c_y, c_z} <= {v[6], v[7], v[8]};
    do @(negedge clk); while (!took_request);
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    while (board.pending_q.size() != 0) @(negedge clk);
  endtask

  function coord_t pick_edge();
    case ($urandom_range(5))
      0: return coord_t'(-131072);
      1: return coord_t'(131071);
      2: return '0;
      3: return coord_t'(1);
      4: return coord_t'(-1);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function coord_t small_val(int span);
    return coord_t'(int'($urandom_range(2 * span)) - span);
  endfunction

  // Random triples: full range, short bonds, collinear and coplanar sets
  function triple_t random_triple();
    triple_t v;
    int mode, span, k1, k2;
    mode = $urandom_range(99);
    if (mode < 45) begin
      foreach (v[i]) v[i] = coord_t'($urandom);
    end else if (mode < 62) begin
      span = (1 << $urandom_range(1, 12));
      foreach (v[i]) v[i] = small_val(span);
    end else if (mode < 72) begin
      // parallel pair gives a zero cross product
      for (int i = 3; i < 9; i++) v[i] = small_val(16384);
      k1 = int'($urandom_range(6)) - 3;
      for (int i = 0; i < 3; i++) begin
        if ($urandom_range(1)) v[i] = coord_t'(k1 * v[3 + i]);
        else v[i] = small_val(16384);
        if ($urandom_range(1)) v[6 + i] = coord_t'(-k1 * v[3 + i]);
      end
    end else if (mode < 86) begin
      // c in the plane of a and b: zero mixed product
      for (int i = 0; i < 6; i++) v[i] = small_val(16384);
      k1 = int'($urandom_range(6)) - 3;
      k2 = int'($urandom_range(6)) - 3;
      for (int i = 0; i < 3; i++) v[6 + i] = coord_t'(k1 * v[i] + k2 * v[3 + i]);
    end else begin
      foreach (v[i]) v[i] = pick_edge();
    end
    return v;
  endfunction

  triple_t directed[$];

  initial begin
    triple_t v;
    board = new();
    rst = 1'b1;
    calm = 1'b0;
    in_valid = 1'b0;
    {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} = '0;
    directed = '{
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 1, 0, 0, 0, 1},
      '{1, 0, 0, 0, 1, 0, 1, 0, 0},
      '{1, 0, 0, 0, 1, 0, -1, 0, 0},
      '{1, 0, 0, 0, 1, 0, 0, 0, -1},
      '{1, 0, 0, 0, 1, 0, 1, 0, 1},
      '{1, 0, 0, 0, 1, 0, 1, 0, -1},
      '{1, 0, 0, 0, 1, 0, -1, 0, -1},
      '{2, 0, 0, 1, 0, 0, 0, 1, 0},
      '{1, 0, 0, 0, 1, 0, 0, 2, 0},
      '{-131072, -131072, -131072, 131071, 131071, 131071, 0, 1, 0},
      '{-131072, 0, 0, 0, -131072, 0, 0, 0, -131072},
      '{131071, 0, 0, 0, 131071, 0, 0, 0, 131071},
      '{131071, -131072, 131071, -131072, 131071, 131071, 131071, 131071, -131072},
      '{-131072, 131071, -131072, 131071, -131072, -131072, -131072, -131072, 131071},
      '{-131072, -131072, -131072, -131072, -131072, -131072, -131072, -131072, -131072},
      '{131071, 131071, 131071, -131072, -131072, 131071, 131071, -131072, -131072},
      '{1, 1, 0, -131072, 131071, 1, 131071, -131072, 0},
      '{3, 4, 5, 7, -2, 1, 3, 4, 5},
      '{-1, -1, -1, -1, -1, -1, -1, -1, -1},
      '{5, -3, 2, 0, 0, 1, -5, 3, -1}
    };
    repeat (9) @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) send_request(directed[i]);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 400 && n < 700);
      if (n == 850) wait_drained();
      v = random_triple();
      send_request(v);
    end
    calm = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (board.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
